// File: hdl/mfre_pkg.sv
package mfre_pkg;

    typedef enum logic [3:0] {
        CMD_POINT   = 4'd0,
        CMD_LINE    = 4'd1,
        CMD_RECT    = 4'd2,
        CMD_FILL    = 4'd3,
        CMD_CLEAR   = 4'd4,
        CMD_INVERT  = 4'd5,
        CMD_CLR_ALL = 4'd6,
        CMD_SET_ALL = 4'd7,
        CMD_RD_PIX  = 4'd8,
        CMD_RD_BYTE = 4'd9
    } cmd_t;

    // pixel write operations
    typedef enum logic [1:0] {
        PIX_CLR = 2'd0,
        PIX_SET = 2'd1,
        PIX_FLIP = 2'd2
    } pix_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_LINE_LOAD,
        ST_LINE_STEP,
        ST_LINE_WR,
        ST_AREA_LOAD,
        ST_AREA_STEP,
        ST_AREA_WR,
        ST_READ,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       latch_req;   // capture request fields
        logic       sweep_init;  // start a whole-store pass
        logic       sweep_step;  // write one byte, advance address
        logic       line_init;   // load line ends from segment number
        logic       line_rd;     // read byte under current line pixel
        logic       line_wr;     // write it back and advance
        logic       area_init;   // load area bounds
        logic       area_rd;
        logic       area_wr;
        logic       read_rd;     // read byte for read commands
        logic       result_load; // capture result
        logic       seg_next;    // next rectangle side
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic line_done;   // last pixel written
        logic area_empty;
        logic area_last;
        logic seg_last;
    } sts_t;

endpackage

// File: hdl/mfre_ctrl.sv
module mfre_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic [3:0]      req_cmd,
    input  logic            res_busy,
    output logic            in_stall,
    output mfre_pkg::ctl_t  ctl,
    input  mfre_pkg::sts_t  sts
);
    import mfre_pkg::*;

    state_t state_reg, state_next;
    logic   clear_reg, clear_next;   // reset clearing pass pending

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            clear_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            clear_reg <= clear_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clear_next = clear_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && !res_busy)
                begin
                    unique case (req_cmd)
                        CMD_POINT, CMD_LINE, CMD_RECT: state_next = ST_LINE_LOAD;
                        CMD_FILL, CMD_CLEAR, CMD_INVERT: state_next = ST_AREA_LOAD;
                        CMD_CLR_ALL, CMD_SET_ALL: state_next = ST_SWEEP;
                        CMD_RD_PIX, CMD_RD_BYTE: state_next = ST_READ;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                    clear_next = 1'b0;
                end
            end
            ST_LINE_LOAD: state_next = ST_LINE_STEP;
            ST_LINE_STEP: state_next = ST_LINE_WR;
            ST_LINE_WR:
            begin
                if (!sts.line_done)
                    state_next = ST_LINE_STEP;
                else if (sts.seg_last)
                    state_next = ST_IDLE;
                else
                    state_next = ST_LINE_LOAD;
            end
            ST_AREA_LOAD: state_next = sts.area_empty ? ST_IDLE : ST_AREA_STEP;
            ST_AREA_STEP: state_next = ST_AREA_WR;
            ST_AREA_WR:   state_next = sts.area_last ? ST_IDLE : ST_AREA_STEP;
            ST_READ:      state_next = ST_RESULT;
            ST_RESULT:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = res_busy;
                ctl.latch_req = req_valid && !res_busy;
                ctl.sweep_init = req_valid && !res_busy;
            end
            ST_SWEEP:     ctl.sweep_step = 1'b1;
            ST_LINE_LOAD: ctl.line_init = 1'b1;
            ST_LINE_STEP: ctl.line_rd = 1'b1;
            ST_LINE_WR:
            begin
                ctl.line_wr = 1'b1;
                ctl.seg_next = sts.line_done;
            end
            ST_AREA_LOAD: ctl.area_init = 1'b1;
            ST_AREA_STEP: ctl.area_rd = 1'b1;
            ST_AREA_WR:   ctl.area_wr = 1'b1;
            ST_READ:      ctl.read_rd = 1'b1;
            ST_RESULT:    ctl.result_load = 1'b1;
            default: ;
        endcase
    end

    // the result state lasts a single cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RESULT |=> state_reg == ST_IDLE)
        else $error("result state held");
    // no request taken during the reset clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> in_stall)
        else $error("request taken during clear");
    // a read always leads to a result
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_RESULT)
        else $error("read lost");
endmodule

// File: hdl/mfre_dpath.sv
module mfre_dpath
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [3:0]      cmd,
    input  logic [7:0]      start_x,
    input  logic [7:0]      start_y,
    input  logic [7:0]      end_x,
    input  logic [7:0]      end_y,
    input  logic [7:0]      area_width,
    input  logic [7:0]      area_height,
    input  logic            ink,
    input  mfre_pkg::ctl_t  ctl,
    output mfre_pkg::sts_t  sts,
    output logic            pixel_value,
    output logic [7:0]      column_byte
);
    import mfre_pkg::*;

    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH = PAGES * SCREEN_WIDTH;
    localparam int CW = $clog2(SCREEN_WIDTH);
    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // latched request
    logic [3:0] cmd_reg;
    logic [7:0] x0_reg, y0_reg, x1_reg, y1_reg, w_reg, h_reg;
    logic       ink_reg;

    // sweep
    logic [AW:0] sw_addr_reg;
    logic [7:0]  sw_data_reg;

    // line engine, signed 10 bit coordinates
    logic signed [9:0] lx_reg, ly_reg, lxe_reg, lye_reg;
    logic signed [9:0] dx_reg, dy_reg, err_reg;
    logic              sx_reg, sy_reg;
    logic [1:0]        seg_reg;

    // area engine
    logic [8:0] ax_reg, ay_reg, ax0_reg, axe_reg, aye_reg;

    // pixel under work
    logic [8:0]  px, py;
    logic        p_on;
    logic [AW-1:0] p_addr;
    logic [2:0]  p_bit;
    logic [AW-1:0] p_addr_reg;
    logic [2:0]  p_bit_reg;
    logic        p_on_reg;
    pix_op_t     op_reg;

    // write port
    logic          we;
    logic [AW-1:0] wa;
    logic [7:0]    wd;

    always_ff @(posedge clk)
    begin
        if (ctl.latch_req)
        begin
            cmd_reg <= cmd;
            x0_reg <= start_x;
            y0_reg <= start_y;
            x1_reg <= end_x;
            y1_reg <= end_y;
            w_reg <= area_width;
            h_reg <= area_height;
            ink_reg <= ink;
        end
    end

    // sweep address and fill value
    assign sts.sweep_last = (sw_addr_reg == (AW+1)'(DEPTH - 1));
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_addr_reg <= '0;
            sw_data_reg <= 8'h00;
        end
        else if (ctl.sweep_init)
        begin
            sw_addr_reg <= '0;
            sw_data_reg <= (cmd == CMD_SET_ALL) ? 8'hFF : 8'h00;
        end
        else if (ctl.sweep_step)
            sw_addr_reg <= sw_addr_reg + 1'b1;
    end

    // line segment ends
    logic [7:0] sxa, sya, sxb, syb;
    always_comb
    begin
        sxa = x0_reg; sya = y0_reg; sxb = x1_reg; syb = y1_reg;
        if (cmd_reg == CMD_POINT)
        begin
            sxb = x0_reg; syb = y0_reg;
        end
        else if (cmd_reg == CMD_RECT)
        begin
            unique case (seg_reg)
                2'd0: begin sya = y0_reg; syb = y0_reg; end
                2'd1: begin sya = y1_reg; syb = y1_reg; end
                2'd2: begin sxa = x0_reg; sxb = x0_reg; end
                default: begin sxa = x1_reg; sxb = x1_reg; end
            endcase
        end
    end

    assign sts.seg_last = (cmd_reg != CMD_RECT) || (seg_reg == 2'd3);
    assign sts.line_done = (lx_reg == lxe_reg) && (ly_reg == lye_reg);

    // error terms compared as signed 11 bit values
    logic signed [10:0] e2, dx_e, ndy_e;
    assign e2 = {err_reg, 1'b0};
    assign dx_e = 11'(dx_reg);
    assign ndy_e = -11'(dy_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.latch_req)
            seg_reg <= 2'd0;
        else if (ctl.seg_next)
            seg_reg <= seg_reg + 2'd1;
        if (ctl.line_init)
        begin
            lx_reg <= signed'({2'b0, sxa});
            ly_reg <= signed'({2'b0, sya});
            lxe_reg <= signed'({2'b0, sxb});
            lye_reg <= signed'({2'b0, syb});
            dx_reg <= (sxb > sxa) ? signed'({2'b0, sxb - sxa}) : signed'({2'b0, sxa - sxb});
            dy_reg <= (syb > sya) ? signed'({2'b0, syb - sya}) : signed'({2'b0, sya - syb});
            err_reg <= ((sxb > sxa) ? signed'({2'b0, sxb - sxa}) : signed'({2'b0, sxa - sxb}))
                     - ((syb > sya) ? signed'({2'b0, syb - sya}) : signed'({2'b0, sya - syb}));
            sx_reg <= sxa < sxb;
            sy_reg <= sya < syb;
        end
        else if (ctl.line_wr && !sts.line_done)
        begin
            if (e2 > ndy_e && e2 < dx_e)
                err_reg <= err_reg - dy_reg + dx_reg;
            else if (e2 > ndy_e)
                err_reg <= err_reg - dy_reg;
            else if (e2 < dx_e)
                err_reg <= err_reg + dx_reg;
            if (e2 > ndy_e)
                lx_reg <= sx_reg ? lx_reg + 10'sd1 : lx_reg - 10'sd1;
            if (e2 < dx_e)
                ly_reg <= sy_reg ? ly_reg + 10'sd1 : ly_reg - 10'sd1;
        end
    end

    // area bounds, clipped; fill uses ends, clear and invert use sizes
    logic [8:0] right, bottom, rclip, bclip;
    always_comb
    begin
        if (cmd_reg == CMD_FILL)
        begin
            right = {1'b0, x1_reg};
            bottom = {1'b0, y1_reg};
        end
        else
        begin
            right = {1'b0, x0_reg} + {1'b0, w_reg};
            bottom = {1'b0, y0_reg} + {1'b0, h_reg};
        end
        rclip = (right > 9'(SCREEN_WIDTH)) ? 9'(SCREEN_WIDTH) : right;
        bclip = (bottom > 9'(SCREEN_HEIGHT)) ? 9'(SCREEN_HEIGHT) : bottom;
    end
    // judged while the bounds load, so taken from the clipped edges directly
    assign sts.area_empty = (ax0_reg >= rclip) || (ay_reg >= bclip);
    assign sts.area_last = (ax_reg + 9'd1 >= axe_reg) && (ay_reg + 9'd1 >= aye_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.latch_req)
        begin
            ax0_reg <= {1'b0, start_x};
            ax_reg <= {1'b0, start_x};
            ay_reg <= {1'b0, start_y};
        end
        else if (ctl.area_init)
        begin
            axe_reg <= rclip;
            aye_reg <= bclip;
        end
        else if (ctl.area_wr)
        begin
            if (ax_reg + 9'd1 >= axe_reg)
            begin
                ax_reg <= ax0_reg;
                ay_reg <= ay_reg + 9'd1;
            end
            else
                ax_reg <= ax_reg + 9'd1;
        end
    end

    // pixel selection
    always_comb
    begin
        if (ctl.line_rd)
        begin
            px = lx_reg[8:0];
            py = ly_reg[8:0];
        end
        else if (ctl.area_rd)
        begin
            px = ax_reg;
            py = ay_reg;
        end
        else
        begin
            px = {1'b0, x0_reg};
            py = {1'b0, y0_reg};
        end
        p_on = (px < 9'(SCREEN_WIDTH)) && (py < 9'(SCREEN_HEIGHT));
        if (PAGES > 1)
            p_addr = AW'(py[PW+2:3]) * AW'(SCREEN_WIDTH) + AW'(px[CW-1:0]);
        else
            p_addr = AW'(px[CW-1:0]);
        p_bit = py[2:0];
    end

    logic byte_on;
    assign byte_on = ({1'b0, x0_reg} < 9'(SCREEN_WIDTH)) && ({4'b0, y0_reg[7:3]} < 9'(PAGES));

    always_ff @(posedge clk)
    begin
        if (ctl.line_rd || ctl.area_rd || ctl.read_rd)
        begin
            p_addr_reg <= p_addr;
            p_bit_reg <= p_bit;
            p_on_reg <= ctl.read_rd ? ((cmd_reg == CMD_RD_BYTE) ? byte_on : p_on) : p_on;
            if (ctl.line_rd)
                op_reg <= (cmd_reg == CMD_RECT || ink_reg) ? PIX_SET : PIX_CLR;
            else
                op_reg <= (cmd_reg == CMD_FILL) ? PIX_SET :
                          (cmd_reg == CMD_INVERT) ? PIX_FLIP : PIX_CLR;
        end
    end

    // read byte address for read byte
    logic [AW-1:0] rd_addr;
    always_comb
    begin
        if (ctl.read_rd && cmd_reg == CMD_RD_BYTE)
            rd_addr = (PAGES > 1) ?
                AW'(y0_reg[PW+2:3]) * AW'(SCREEN_WIDTH) + AW'(x0_reg[CW-1:0]) :
                AW'(x0_reg[CW-1:0]);
        else
            rd_addr = p_addr;
    end

    logic [7:0] mod;
    always_comb
    begin
        unique case (op_reg)
            PIX_SET:  mod = rd_data_reg | (8'd1 << p_bit_reg);
            PIX_FLIP: mod = rd_data_reg ^ (8'd1 << p_bit_reg);
            default:  mod = rd_data_reg & ~(8'd1 << p_bit_reg);
        endcase
    end

    assign we = ctl.sweep_step || ((ctl.line_wr || ctl.area_wr) && p_on_reg);
    assign wa = ctl.sweep_step ? sw_addr_reg[AW-1:0] : p_addr_reg;
    assign wd = ctl.sweep_step ? sw_data_reg : mod;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_data_reg <= mem[rd_addr];
    end

    // result registers load once per read and hold while the result waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_value <= 1'b0;
            column_byte <= 8'h00;
        end
        else if (ctl.result_load)
        begin
            pixel_value <= (cmd_reg == CMD_RD_PIX) && p_on_reg && rd_data_reg[p_bit_reg];
            column_byte <= ((cmd_reg == CMD_RD_BYTE) && p_on_reg) ? rd_data_reg : 8'h00;
        end
    end

    // sweep stays within the store
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.sweep_step |-> sw_addr_reg < (AW+1)'(DEPTH))
        else $error("sweep overrun");
    // writes never land off screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.line_wr || ctl.area_wr) && we |-> p_addr_reg < AW'(DEPTH - 1) || p_addr_reg == AW'(DEPTH - 1))
        else $error("write address out of range");
    // a line step moves x by at most one pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(ctl.line_wr) && !$past(ctl.line_init) |->
        (lx_reg - $past(lx_reg) <= 10'sd1) && ($past(lx_reg) - lx_reg <= 10'sd1))
        else $error("line stepped too far");
endmodule

// File: hdl/mono_framebuffer_raster_engine.sv
// sequence: a point and each line side take a load state, then a read state and a write state per
// pixel; an area takes a load state, then a read and a write state per pixel; a read takes a read
// state, then a result state; clear all and light all sweep every store byte
// requests: one at a time, each pixel a read-modify-write of its column byte on the single write port
// reset: asynchronous, active low; a clearing pass over all pages*width store bytes (1024 by default)
// zeroes the store, and requests are stalled until it ends
module mono_framebuffer_raster_engine
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] cmd,
    input  logic [7:0] start_x,
    input  logic [7:0] start_y,
    input  logic [7:0] end_x,
    input  logic [7:0] end_y,
    input  logic [7:0] area_width,
    input  logic [7:0] area_height,
    input  logic       ink,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       pixel_value,
    output logic [7:0] column_byte
);
    import mfre_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic res_reg;  // result waiting at the output

    // controller: sequences sweep, line, area and read phases
    mfre_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_cmd   (cmd),
        .res_busy  (res_reg && out_stall),
        .in_stall  (in_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    // result is held until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_reg <= 1'b0;
        else if (ctl.result_load)
            res_reg <= 1'b1;
        else if (!out_stall)
            res_reg <= 1'b0;
    end
    assign out_valid = res_reg;

    mfre_dpath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .area_width  (area_width),
        .area_height (area_height),
        .ink         (ink),
        .ctl         (ctl),
        .sts         (sts),
        .pixel_value (pixel_value),
        .column_byte (column_byte)
    );
endmodule
